// ===== design/tron_pkg.sv =====
// Shared types and constants for the telnet receive option negotiator.
// Used by tron_front, tron_queue, tron_back and the top level.
// No dependencies.
package tron_pkg;

  // Telnet command and data byte values
  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_DM   = 8'd242;
  localparam logic [7:0] B_CR   = 8'd13;
  localparam logic [7:0] B_LF   = 8'd10;

  // Options that are negotiated; all others are always off
  localparam logic [7:0] OPT_ECHO = 8'd1;
  localparam logic [7:0] OPT_SGA  = 8'd3;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Receive phase of the IAC machine
  typedef enum logic [2:0] {
    PH_DATA = 3'd0,
    PH_IAC  = 3'd1,
    PH_WILL = 3'd2,
    PH_WONT = 3'd3,
    PH_DO   = 3'd4,
    PH_DONT = 3'd5
  } phase_t;

  // Result word kind
  typedef enum logic [1:0] {
    KIND_TERM  = 2'd0,
    KIND_NET   = 2'd1,
    KIND_FLUSH = 2'd2
  } kind_t;

  // Work handed from front to back
  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,  // one byte to terminal
    CMD_CRLF  = 2'd1,  // CR then LF to terminal
    CMD_FLUSH = 2'd2,  // flush terminal output
    CMD_REPLY = 2'd3   // IAC, verb, option to network
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] verb;
    logic [7:0] arg;
    logic       echo;
  } cmd_t;

endpackage

// ===== design/telnet_receive_option_negotiator_top.sv =====
// Top level of the telnet receive option negotiator.
// Depends on tron_pkg, tron_front, tron_queue and tron_back.
//
//  Channel  Direction  Ports                     Contents
//  in_      slave      tvalid tready tdata[7:0]  rx_byte
//  out_     master     tvalid tready tdata tuser tlast  result words
//  cfg_     write      wr_en wr_data             map_cr_to_crlf
//
// The front end takes one received byte per cycle while the queue has room.
// Each word leaves through a registered output one per cycle while out_tready
// is high: a data byte gives one word (two for CR with mapping), a reply three,
// so the back end sets the rate when replies or CR/LF pairs come in a row.
// Reset (rst_n low, synchronous) clears phase, option flags and queue and
// sets local echo. Output stalls fill the queue and then drop in_tready.
module telnet_receive_option_negotiator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,   // map_cr_to_crlf
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,     // [7:0] out_byte, [8] local_echo, rest zero
  output logic [1:0]  out_tuser,     // [1:0] out_kind
  output logic        out_tlast      // last_of_run
);

  logic           q_full, q_push, q_pop, q_valid;
  tron_pkg::cmd_t q_cmd, head_cmd;
  tron_pkg::kind_t kind;
  logic [7:0]     byte_w;
  logic           echo_w;

  tron_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_tvalid),
    .in_byte     (in_tdata),
    .in_ready    (in_tready),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_cmd)
  );

  tron_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  tron_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head_cmd   (head_cmd),
    .pop        (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (kind),
    .out_byte   (byte_w),
    .out_echo   (echo_w),
    .out_last   (out_tlast)
  );

  assign out_tdata = {7'd0, echo_w, byte_w};
  assign out_tuser = kind;

endmodule

// ===== design/tron_front.sv =====
// Front end: IAC phase machine, option flags and echo mode; turns each
// received byte into at most one command word for the back end.
// Depends on tron_pkg.
module tron_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic            cfg_wr_data,
  input  logic            in_valid,
  input  logic [7:0]      in_byte,
  output logic            in_ready,
  input  logic            q_full,
  output logic            q_push,
  output tron_pkg::cmd_t  q_cmd
);

  tron_pkg::phase_t phase_r, phase_nxt;
  logic map_cr_r;
  logic peer_echo_r, peer_echo_nxt;
  logic peer_sga_r, peer_sga_nxt;
  logic loc_echo_r, loc_echo_nxt;
  logic loc_sga_r, loc_sga_nxt;
  logic echo_mode_r, echo_mode_nxt;
  logic fire;
  logic is_echo, is_sga;
  logic peer_on, loc_on;
  logic has_result;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;
  assign is_echo  = (in_byte == tron_pkg::OPT_ECHO);
  assign is_sga   = (in_byte == tron_pkg::OPT_SGA);
  assign peer_on  = (is_echo && peer_echo_r) || (is_sga && peer_sga_r);
  assign loc_on   = (is_echo && loc_echo_r) || (is_sga && loc_sga_r);

  // Next phase
  always_comb begin
    phase_nxt = tron_pkg::PH_DATA;
    case (phase_r)
      tron_pkg::PH_DATA: begin
        if (in_byte == tron_pkg::B_IAC) phase_nxt = tron_pkg::PH_IAC;
      end
      tron_pkg::PH_IAC: begin
        if (in_byte == tron_pkg::B_WILL)      phase_nxt = tron_pkg::PH_WILL;
        else if (in_byte == tron_pkg::B_WONT) phase_nxt = tron_pkg::PH_WONT;
        else if (in_byte == tron_pkg::B_DO)   phase_nxt = tron_pkg::PH_DO;
        else if (in_byte == tron_pkg::B_DONT) phase_nxt = tron_pkg::PH_DONT;
      end
      default: phase_nxt = tron_pkg::PH_DATA;
    endcase
  end

  // Commands and flag updates per phase
  always_comb begin
    has_result    = 1'b0;
    q_cmd.op      = tron_pkg::CMD_DATA;
    q_cmd.verb    = 8'd0;
    q_cmd.arg     = in_byte;
    peer_echo_nxt = peer_echo_r;
    peer_sga_nxt  = peer_sga_r;
    loc_echo_nxt  = loc_echo_r;
    loc_sga_nxt   = loc_sga_r;
    echo_mode_nxt = echo_mode_r;
    case (phase_r)
      tron_pkg::PH_IAC: begin
        if (in_byte == tron_pkg::B_DM) begin
          has_result = 1'b1;
          q_cmd.op   = tron_pkg::CMD_FLUSH;
          q_cmd.arg  = 8'd0;
        end else if (in_byte == tron_pkg::B_IAC) begin
          has_result = 1'b1;
        end
      end
      tron_pkg::PH_WILL: begin
        if (!peer_on) begin
          has_result = 1'b1;
          q_cmd.op   = tron_pkg::CMD_REPLY;
          if (is_echo || is_sga) begin
            q_cmd.verb = tron_pkg::B_DO;
            if (is_echo) begin
              echo_mode_nxt = 1'b0;
              peer_echo_nxt = 1'b1;
            end else begin
              peer_sga_nxt = 1'b1;
            end
          end else begin
            q_cmd.verb = tron_pkg::B_DONT;
          end
        end
      end
      tron_pkg::PH_WONT: begin
        // peer flag can only be on for ECHO or SGA
        if (peer_on) begin
          has_result = 1'b1;
          q_cmd.op   = tron_pkg::CMD_REPLY;
          q_cmd.verb = tron_pkg::B_DONT;
          if (is_echo) begin
            echo_mode_nxt = 1'b1;
            peer_echo_nxt = 1'b0;
          end else begin
            peer_sga_nxt = 1'b0;
          end
        end
      end
      tron_pkg::PH_DO: begin
        if (!loc_on) begin
          has_result = 1'b1;
          q_cmd.op   = tron_pkg::CMD_REPLY;
          if (is_echo) begin
            q_cmd.verb    = tron_pkg::B_WILL;
            echo_mode_nxt = 1'b1;
            peer_echo_nxt = 1'b0;
            loc_echo_nxt  = 1'b1;
          end else if (is_sga) begin
            q_cmd.verb  = tron_pkg::B_WILL;
            loc_sga_nxt = 1'b1;
          end else begin
            q_cmd.verb = tron_pkg::B_WONT;
          end
        end
      end
      tron_pkg::PH_DONT: begin
        if (loc_on) begin
          has_result = 1'b1;
          q_cmd.op   = tron_pkg::CMD_REPLY;
          q_cmd.verb = tron_pkg::B_WONT;
          if (is_echo) loc_echo_nxt = 1'b0;
          else         loc_sga_nxt  = 1'b0;
        end
      end
      default: begin
        // data phase; out-of-range codes behave the same
        if (in_byte != tron_pkg::B_IAC) begin
          has_result = 1'b1;
          if (in_byte == tron_pkg::B_CR && map_cr_r) q_cmd.op = tron_pkg::CMD_CRLF;
        end
      end
    endcase
    q_cmd.echo = echo_mode_nxt;
  end

  assign q_push = fire && has_result;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= tron_pkg::PH_DATA;
      map_cr_r    <= 1'b0;
      peer_echo_r <= 1'b0;
      peer_sga_r  <= 1'b0;
      loc_echo_r  <= 1'b0;
      loc_sga_r   <= 1'b0;
      echo_mode_r <= 1'b1;
    end else begin
      if (cfg_wr_en) map_cr_r <= cfg_wr_data;
      if (fire) begin
        phase_r     <= phase_nxt;
        peer_echo_r <= peer_echo_nxt;
        peer_sga_r  <= peer_sga_nxt;
        loc_echo_r  <= loc_echo_nxt;
        loc_sga_r   <= loc_sga_nxt;
        echo_mode_r <= echo_mode_nxt;
      end
    end
  end

endmodule

// ===== design/tron_queue.sv =====
// Short command queue between front and back ends.
// Depends on tron_pkg.
module tron_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tron_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output tron_pkg::cmd_t  head_cmd
);

  tron_pkg::cmd_t entry_r [tron_pkg::QDEPTH];
  logic [tron_pkg::QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [tron_pkg::QCW-1:0] count_r;
  logic do_push, do_pop;

  assign full       = (count_r == tron_pkg::QCW'(tron_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_cmd;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ===== design/tron_back.sv =====
// Back end: expands each queued command into one to three result words
// and holds the current word in an output register.
// Depends on tron_pkg.
module tron_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  tron_pkg::cmd_t  head_cmd,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output tron_pkg::kind_t out_kind,
  output logic [7:0]      out_byte,
  output logic            out_echo,
  output logic            out_last
);

  logic [1:0] cnt_r;
  logic       valid_r;
  tron_pkg::kind_t kind_r, kind_w;
  logic [7:0] byte_r, byte_w;
  logic       echo_r, last_r, last_w;
  logic       load;

  assign load = head_valid && (!valid_r || out_ready);
  assign pop  = load && last_w;

  // Word selection for the current step of the head command
  always_comb begin
    kind_w = tron_pkg::KIND_TERM;
    byte_w = head_cmd.arg;
    last_w = 1'b1;
    case (head_cmd.op)
      tron_pkg::CMD_CRLF: begin
        last_w = (cnt_r == 2'd1);
        if (cnt_r != 2'd0) byte_w = tron_pkg::B_LF;
      end
      tron_pkg::CMD_FLUSH: begin
        kind_w = tron_pkg::KIND_FLUSH;
        byte_w = 8'd0;
      end
      tron_pkg::CMD_REPLY: begin
        kind_w = tron_pkg::KIND_NET;
        last_w = (cnt_r == 2'd2);
        if (cnt_r == 2'd0)      byte_w = tron_pkg::B_IAC;
        else if (cnt_r == 2'd1) byte_w = head_cmd.verb;
      end
      default: begin
        last_w = 1'b1;
      end
    endcase
  end

  // Step counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        cnt_r   <= last_w ? 2'd0 : cnt_r + 2'd1;
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= kind_w;
      byte_r <= byte_w;
      echo_r <= head_cmd.echo;
      last_r <= last_w;
    end
  end

  assign out_valid = valid_r;
  assign out_kind  = kind_r;
  assign out_byte  = byte_r;
  assign out_echo  = echo_r;
  assign out_last  = last_r;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for telnet_receive_option_negotiator_top.
// Drives received bytes, predicts terminal/network/flush words in-line and
// checks every output word. Depends on tron_pkg and the block's RTL.
`timescale 1ns / 100ps

module testbench;
  import tron_pkg::*;

  // Command and option bytes not in the package
  localparam logic [7:0] B_NOP  = 8'd241;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] OPT_TM = 8'd6;

  localparam int HOLD_CYCLES   = 200;     // long receiver hold-off
  localparam int SETTLE_CYCLES = 24;      // queue depth plus pipeline slack
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_REPORTS   = 10;

  // Opening sequence: field extremes, CR mapping, IAC escape, DM, SB, WILL, DO, DONT
  localparam logic [7:0] OPENING [25] = '{
    8'h00, B_CR, 8'h80, 8'hFE,
    B_IAC, B_IAC,
    B_IAC, B_DM,
    B_IAC, B_SB,
    B_IAC, B_WILL, OPT_ECHO,
    B_IAC, B_WILL, OPT_ECHO,
    B_IAC, B_DO, OPT_ECHO,
    B_IAC, B_DONT, OPT_ECHO,
    B_IAC, B_DO, OPT_TM
  };

  typedef struct {
    kind_t      kind;
    logic [7:0] data;
    logic       echo;
    logic       last;
  } tn_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;    // [7:0] out_byte, [8] local_echo, rest zero
  logic [1:0]  out_tuser;    // [1:0] out_kind
  logic        out_tlast;

  telnet_receive_option_negotiator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Shadow negotiator state
  phase_t   rx_ph;
  bit       peer_on  [256];
  bit       local_on [256];
  bit       echo_local;
  bit       crlf_map;

  logic [7:0] rx_bytes_pending [$];
  tn_word_t   step_words [$];
  tn_word_t   decoded_words [$];

  int send_max = 0;
  int recv_max = 0;
  int send_wait = 0;
  int recv_wait = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int cycles = 0;
  int bytes_sent = 0;
  int words_checked = 0;
  int net_words = 0;
  int flushes = 0;
  int mismatches = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void add_word(kind_t k, logic [7:0] d);
    tn_word_t w;
    w.kind = k;
    w.data = d;
    w.echo = 1'b0;
    w.last = 1'b0;
    step_words.push_back(w);
  endfunction

  function automatic void add_reply(logic [7:0] verb, logic [7:0] opt);
    add_word(KIND_NET, B_IAC);
    add_word(KIND_NET, verb);
    add_word(KIND_NET, opt);
  endfunction

  // Advance the shadow IAC machine by one byte and queue the words it causes
  function automatic void decode_rx_byte(logic [7:0] c);
    phase_t ph;
    ph = rx_ph;
    rx_ph = PH_DATA;
    step_words.delete();
    case (ph)
      PH_IAC: begin
        if (c == B_WILL) rx_ph = PH_WILL;
        else if (c == B_WONT) rx_ph = PH_WONT;
        else if (c == B_DO) rx_ph = PH_DO;
        else if (c == B_DONT) rx_ph = PH_DONT;
        else if (c == B_DM) add_word(KIND_FLUSH, 8'd0);
        else if (c == B_IAC) add_word(KIND_TERM, B_IAC);
      end
      PH_WILL: begin
        if (!peer_on[c]) begin
          if (c == OPT_ECHO || c == OPT_SGA) begin
            if (c == OPT_ECHO) echo_local = 1'b0;
            peer_on[c] = 1'b1;
            add_reply(B_DO, c);
          end else begin
            add_reply(B_DONT, c);
          end
        end
      end
      PH_WONT: begin
        if (peer_on[c]) begin
          if (c == OPT_ECHO) echo_local = 1'b1;
          if (c == OPT_ECHO || c == OPT_SGA) peer_on[c] = 1'b0;
          add_reply(B_DONT, c);
        end
      end
      PH_DO: begin
        if (!local_on[c]) begin
          if (c == OPT_ECHO) begin
            echo_local = 1'b1;
            peer_on[c] = 1'b0;
            local_on[c] = 1'b1;
            add_reply(B_WILL, c);
          end else if (c == OPT_SGA) begin
            local_on[c] = 1'b1;
            add_reply(B_WILL, c);
          end else begin
            add_reply(B_WONT, c);
          end
        end
      end
      PH_DONT: begin
        if (local_on[c]) begin
          local_on[c] = 1'b0;
          add_reply(B_WONT, c);
        end
      end
      default: begin
        if (c == B_IAC) begin
          rx_ph = PH_IAC;
        end else begin
          add_word(KIND_TERM, c);
          if (c == B_CR && crlf_map) add_word(KIND_TERM, B_LF);
        end
      end
    endcase
    // echo mode is the one after the byte; last word of the run is tagged
    foreach (step_words[i]) begin
      step_words[i].echo = echo_local;
      step_words[i].last = (i == step_words.size() - 1);
      decoded_words.push_back(step_words[i]);
    end
  endfunction

  // Mostly well-formed telnet sequences with random content, some noise
  task automatic queue_random_bytes(int count);
    int start;
    int pick;
    logic [7:0] opt;
    start = rx_bytes_pending.size();
    while (rx_bytes_pending.size() - start < count) begin
      pick = $urandom_range(0, 19);
      if (pick < 8) begin
        // plain data, CR weighted up
        if ($urandom_range(0, 5) == 0) rx_bytes_pending.push_back(B_CR);
        else rx_bytes_pending.push_back(8'($urandom_range(0, 254)));
      end else if (pick == 8 || pick == 9) begin
        rx_bytes_pending.push_back(B_IAC);
        rx_bytes_pending.push_back(B_IAC);
      end else if (pick == 10) begin
        rx_bytes_pending.push_back(B_IAC);
        rx_bytes_pending.push_back(B_DM);
      end else if (pick == 11) begin
        // command byte below WILL: ignored (NOP, GA, SB and the rest) unless it is DM
        rx_bytes_pending.push_back(B_IAC);
        rx_bytes_pending.push_back(8'($urandom_range(0, 250)));
      end else if (pick < 19) begin
        case ($urandom_range(0, 9))
          0, 1, 2: opt = OPT_ECHO;
          3, 4:    opt = OPT_SGA;
          5:       opt = OPT_TM;
          6:       opt = 8'd0;
          7:       opt = 8'd255;
          default: opt = 8'($urandom_range(0, 255));
        endcase
        rx_bytes_pending.push_back(B_IAC);
        case ($urandom_range(0, 3))
          0:       rx_bytes_pending.push_back(B_WILL);
          1:       rx_bytes_pending.push_back(B_WONT);
          2:       rx_bytes_pending.push_back(B_DO);
          default: rx_bytes_pending.push_back(B_DONT);
        endcase
        rx_bytes_pending.push_back(opt);
      end else begin
        // noise: any byte, may leave a sequence broken
        rx_bytes_pending.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Wait until all bytes went in and all words came out, then let it settle
  task automatic wait_drained();
    @(negedge clk);
    while (rx_bytes_pending.size() != 0 || in_tvalid || decoded_words.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_crlf_map(bit v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    crlf_map = v;
    @(negedge clk);
  endtask

  // Sender: one byte per handshake, random gap drawn after each byte
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_wait = 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        decode_rx_byte(in_tdata);
        bytes_sent++;
        send_wait = $urandom_range(0, send_max);
      end
      if (send_wait > 0) begin
        send_wait--;
        in_tvalid <= 1'b0;
      end else if (rx_bytes_pending.size() > 0) begin
        in_tdata  <= rx_bytes_pending.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: check each word, then stall at random or for a long hold-off
  always @(posedge clk) begin
    tn_word_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (decoded_words.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected word: kind %0d tdata %h last %b",
                     out_tuser, out_tdata, out_tlast);
        end else begin
          want = decoded_words.pop_front();
          if (out_tuser !== want.kind || out_tdata !== {7'd0, want.echo, want.data} ||
              out_tlast !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("word %0d: want kind %0d byte %h echo %b last %b, got kind %0d tdata %h last %b",
                       words_checked, want.kind, want.data, want.echo, want.last,
                       out_tuser, out_tdata, out_tlast);
          end
          if (want.kind == KIND_NET) net_words++;
          if (want.kind == KIND_FLUSH) flushes++;
        end
        words_checked++;
        recv_wait = $urandom_range(0, recv_max);
      end
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        recv_wait = HOLD_CYCLES;
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, decoded_words.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rx_ph = PH_DATA;
    foreach (peer_on[i]) begin
      peer_on[i]  = 1'b0;
      local_on[i] = 1'b0;
    end
    echo_local = 1'b1;
    crlf_map   = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Opening sequence, CR mapping on, no idling
    write_crlf_map(1'b1);
    foreach (OPENING[i]) rx_bytes_pending.push_back(OPENING[i]);
    wait_drained();

    // Random traffic, mapping off, both sides idling
    write_crlf_map(1'b0);
    send_max = 12;
    recv_max = 12;
    queue_random_bytes(80);
    wait_drained();

    // Back-pressure: receiver holds off while sender streams back to back
    write_crlf_map(1'b1);
    send_max = 0;
    recv_max = 0;
    hold_seq++;
    queue_random_bytes(60);
    wait_drained();

    // Random traffic again, mixed idling
    send_max = 12;
    recv_max = 6;
    queue_random_bytes(40);
    wait_drained();
    write_crlf_map(1'b0);
    send_max = 3;
    recv_max = 12;
    queue_random_bytes(50);
    wait_drained();

    $display("%0d bytes sent, %0d words checked (%0d network, %0d flush), CR mapping on and off",
             bytes_sent, words_checked, net_words, flushes);
    $display("%0d mismatches, %0d words outstanding", mismatches, decoded_words.size());
    if (mismatches == 0 && decoded_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/tron_pkg.sv
design/tron_front.sv
design/tron_queue.sv
design/tron_back.sv
design/telnet_receive_option_negotiator_top.sv
verif/testbench.sv
